FILE: rtl/prime_factor_count_range_query_core_defines.svh
// ----------------------------------------------------------------------------
// Prime factor count core assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef PRIME_FACTOR_COUNT_RANGE_QUERY_CORE_DEFINES_SVH
`define PRIME_FACTOR_COUNT_RANGE_QUERY_CORE_DEFINES_SVH

// Check a consequence in the same cycle.
`define PFC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define PFC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime factor count core package
// Word types, codes and widths shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int FIELD_W         = 17;
  localparam int ENTRY_W         = 5;
  localparam int TABLE_DEPTH_DEF = 131072;

  localparam logic [FIELD_W-1:0] LIMIT_RESET = 17'd100000;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX   = 5'd31;

  localparam logic OP_BUILD = 1'b0;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_t;

  typedef struct packed {
    logic               operation;
    logic [FIELD_W-1:0] range_low;
    logic [FIELD_W-1:0] range_high;
    logic [ENTRY_W-1:0] factor_target;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] match_count;
    status_t            status;
  } out_word_t;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR,
    DP_SCAN,
    DP_PRD,
    DP_PNEXT,
    DP_QINIT,
    DP_INC,
    DP_MUL,
    DP_QNEXT
  } dp_op_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic range_bad;
    logic scan_last;
    logic clr_last;
    logic p_over;
    logic p_last;
    logic is_prime;
    logic inc_last;
    logic q_fits;
  } dp_sts_t;

endpackage

FILE: rtl/pfc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime factor count datapath
// Limit register, factor count memory, sieve counters and range counter.
// ----------------------------------------------------------------------------
module pfc_dp
  import pfc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr,
  input  logic [FIELD_W-1:0] cfg_data,
  input  in_word_t           req,
  input  dp_op_t             cmd,
  output dp_sts_t            sts,
  output logic [FIELD_W-1:0] match_count
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int VAL_W  = FIELD_W + 1;
  localparam int PROD_W = 2 * FIELD_W;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  logic [FIELD_W-1:0] upper_limit;
  logic [FIELD_W-1:0] lim;
  logic [FIELD_W-1:0] lo;
  logic [FIELD_W-1:0] hi;
  logic [ENTRY_W-1:0] k;
  logic [FIELD_W-1:0] m;
  logic [FIELD_W-1:0] p;
  logic [FIELD_W-1:0] q;
  logic [PROD_W-1:0]  prod;
  logic [FIELD_W-1:0] count;
  logic [ADDR_W-1:0]  wb_addr;
  logic               wb_valid;
  logic               scan_vld;
  logic [ENTRY_W-1:0] rd_data;

  logic [VAL_W-1:0]   m_step;
  logic [ENTRY_W-1:0] inc_val;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;

  // clamp the limit to the table
  assign lim = (32'(upper_limit) > 32'(TABLE_DEPTH - 1)) ? FIELD_W'(TABLE_DEPTH - 1)
                                                         : upper_limit;

  assign m_step  = VAL_W'(m) + VAL_W'(q);
  assign inc_val = (rd_data == ENTRY_MAX) ? ENTRY_MAX : rd_data + 1'b1;

  assign sts.range_bad = (lo == '0) || (lo > hi) || (hi > lim);
  assign sts.scan_last = (m == hi);
  assign sts.clr_last  = (m == lim);
  assign sts.p_over    = (p > lim);
  assign sts.p_last    = (p == lim);
  assign sts.is_prime  = (rd_data == '0);
  assign sts.inc_last  = (m_step > VAL_W'(lim));
  assign sts.q_fits    = (prod <= PROD_W'(lim));

  assign match_count = count;

  // memory port steering: clear sweep or pending increment write-back
  assign mem_we    = (cmd == DP_CLR) || wb_valid;
  assign mem_waddr = (cmd == DP_CLR) ? ADDR_W'(m) : wb_addr;
  assign mem_wdata = (cmd == DP_CLR) ? '0 : inc_val;
  assign mem_re    = (cmd == DP_SCAN) || (cmd == DP_PRD) || (cmd == DP_INC);
  assign mem_raddr = (cmd == DP_PRD) ? ADDR_W'(p) : ADDR_W'(m);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= LIMIT_RESET;
      wb_valid    <= 1'b0;
      scan_vld    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        upper_limit <= cfg_data;
      end
      wb_valid <= (cmd == DP_INC);
      scan_vld <= (cmd == DP_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_INC) begin
      wb_addr <= ADDR_W'(m);
    end
    // count the previous scan read
    if (scan_vld && (rd_data == k)) begin
      count <= count + 1'b1;
    end
    case (cmd) inside
      DP_LOAD: begin
        lo    <= req.range_low;
        hi    <= req.range_high;
        k     <= req.factor_target;
        m     <= (req.operation == OP_BUILD) ? '0 : req.range_low;
        p     <= FIELD_W'(2);
        count <= '0;
      end
      DP_CLR, DP_SCAN: begin
        m <= m + 1'b1;
      end
      DP_PNEXT: begin
        p <= p + 1'b1;
      end
      DP_QINIT: begin
        q <= p;
        m <= p;
      end
      DP_INC: begin
        m <= FIELD_W'(m_step);
      end
      DP_MUL: begin
        prod <= PROD_W'(q) * PROD_W'(p);
      end
      DP_QNEXT: begin
        q <= FIELD_W'(prod);
        m <= FIELD_W'(prod);
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/pfc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime factor count controller
// Sequences the clear sweep, the sieve passes and the range scan.
// ----------------------------------------------------------------------------
module pfc_ctrl
  import pfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    start_op,
  input  logic    cfg_wr,
  input  dp_sts_t sts,
  output dp_op_t  cmd,
  output logic    busy,
  output logic    done,
  output status_t status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_CLEAR,
    S_PRD,
    S_PCHK,
    S_INC,
    S_MUL,
    S_QCHK
  } state_t;

  state_t  state;
  state_t  state_next;
  logic    done_next;
  status_t status_next;
  logic    built;
  logic    built_next;

  always_comb begin
    state_next  = state;
    cmd         = DP_NOP;
    done_next   = 1'b0;
    status_next = status;
    built_next  = built;
    unique case (state) inside
      S_IDLE: begin
        if (start) begin
          cmd        = DP_LOAD;
          state_next = (start_op == OP_BUILD) ? S_CLEAR : S_CHECK;
        end
      end
      S_CHECK: begin
        if (!built) begin
          status_next = ST_NOT_BUILT;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (sts.range_bad) begin
          status_next = ST_BAD_RANGE;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd = DP_SCAN;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        status_next = ST_OK;
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end
      S_CLEAR: begin
        cmd = DP_CLR;
        if (sts.clr_last) begin
          if (sts.p_over) begin
            built_next  = 1'b1;
            status_next = ST_OK;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            state_next = S_PRD;
          end
        end
      end
      S_PRD: begin
        cmd        = DP_PRD;
        state_next = S_PCHK;
      end
      S_PCHK, S_QCHK: begin
        if ((state == S_PCHK) && sts.is_prime) begin
          cmd        = DP_QINIT;
          state_next = S_INC;
        end else if ((state == S_QCHK) && sts.q_fits) begin
          cmd        = DP_QNEXT;
          state_next = S_INC;
        end else begin
          cmd = DP_PNEXT;
          if (sts.p_last) begin
            built_next  = 1'b1;
            status_next = ST_OK;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            state_next = S_PRD;
          end
        end
      end
      S_INC: begin
        cmd = DP_INC;
        if (sts.inc_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd        = DP_MUL;
        state_next = S_QCHK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // drop the table on any limit write
    if (cfg_wr) begin
      built_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= 1'b0;
      done   <= 1'b0;
      status <= ST_OK;
      built  <= 1'b0;
    end else begin
      state  <= state_next;
      busy   <= (state_next != S_IDLE);
      done   <= done_next;
      status <= status_next;
      built  <= built_next;
    end
  end

endmodule

FILE: rtl/prime_factor_count_range_query_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime factor count range query core
// Big-omega sieve table with range counting of entries equal to a target.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a request word is taken on a clock edge with start high
//   and busy low. operation 0 builds the table for 0..limit, operation 1
//   counts numbers in range_low..range_high whose prime factor count with
//   multiplicity equals factor_target.
//   Result channel: done pulses for one cycle with the result word; the
//   receiver cannot hold it off, so capture it in that cycle.
//   Config channel: cfg_data is written into upper_limit when cfg_valid and
//   cfg_ready are high; cfg_ready is low while a command is in progress.
//   A limit write invalidates the table.
// Sequencing (factor count memory with one read and one write port):
//   error query: done follows the check state after accept.
//   good query: check, scan with one memory read per number, then drain.
//   build: a clear sweep over 0..limit, a read and a check per candidate p,
//   and per prime power q up to the limit an increment of each multiple of q.
//   One command is in flight at a time.
// Reset: table invalid, limit 100000, memory contents left as they were.
// ----------------------------------------------------------------------------
`include "prime_factor_count_range_query_core_defines.svh"

module prime_factor_count_range_query_core
  import pfc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // command word in
  input  logic               start,
  output logic               busy,
  input  in_word_t           request,
  // result word out
  output logic               done,
  output out_word_t          result,
  // limit register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FIELD_W-1:0] cfg_data
);

  dp_op_t             cmd;
  dp_sts_t            sts;
  status_t            status;
  logic [FIELD_W-1:0] count;
  logic               cfg_wr;

  // hold off limit writes while a command runs
  assign cfg_ready = ~busy;
  assign cfg_wr    = cfg_valid & cfg_ready;

  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .start_op (request.operation),
    .cfg_wr   (cfg_wr),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done),
    .status   (status)
  );

  pfc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .cfg_data    (cfg_data),
    .req         (request),
    .cmd         (cmd),
    .sts         (sts),
    .match_count (count)
  );

  // error results and builds carry a zero count (cleared at load)
  assign result.match_count = count;
  assign result.status      = status;

  `PFC_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while still busy")
  `PFC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `PFC_ASSERT_SAME(a_err_zero, done && (result.status != ST_OK), result.match_count == '0,
                   "error result with nonzero count")

endmodule
